>>> hdl/kwa_pkg.sv
`timescale 1ns / 1ps

package kwa_pkg;

	// Table geometry.
	localparam int ENTRIES = 8;
	localparam int WINDOW = 40;

	// Field widths fixed by the item format.
	localparam int KEY_W = 16;
	localparam int SAMPLE_W = 16;
	localparam int AVG_W = 16;

	localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int POS_W = $clog2(WINDOW + 1);
	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W = SUM_W + RECIP_W;
	localparam int MEM_DEPTH = ENTRIES * WINDOW;
	localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	// Command queue between the front and the back; depth is a power of two.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Reciprocal of WINDOW scaled by 2^SUM_W, rounded down.
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SUM_W) / WINDOW);
	// Bias that moves every possible RSSI sum into the unsigned range.
	localparam logic [SUM_W-1:0] RSSI_BIAS = SUM_W'(WINDOW * 32768);

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_UPDATE = 2'd1,
		MODE_DELETE = 2'd2,
		MODE_QUERY  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_FULL      = 3'd2,
		ST_PRESENT   = 3'd3,
		ST_ADDR_ZERO = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_REPORT = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_UPDATE = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef struct packed {
		mode_t                       mode;
		logic [KEY_W-1:0]            node_address;
		logic [SAMPLE_W-1:0]         range_sample;
		logic signed [SAMPLE_W-1:0]  rssi_sample;
	} req_t;

	typedef struct packed {
		status_t                     status;
		logic [AVG_W-1:0]            range_mean;
		logic signed [AVG_W-1:0]     rssi_mean;
	} rsp_t;

	typedef struct packed {
		op_t                         op;
		logic [SLOT_W-1:0]           slot;
		status_t                     status;
		logic [SAMPLE_W-1:0]         range_sample;
		logic signed [SAMPLE_W-1:0]  rssi_sample;
	} cmd_t;

	// Finishes x / WINDOW from prod = x * RECIP. The estimate is low by at
	// most one, so one compare and subtract corrects it.
	function automatic logic [AVG_W-1:0] win_quot(input logic [PROD_W-1:0] prod,
			input logic [SUM_W-1:0] x);
		logic [SUM_W-1:0] q;
		logic [SUM_W-1:0] r;
		q = prod[2*SUM_W-1:SUM_W];
		r = x - SUM_W'(q * SUM_W'(WINDOW));
		if (r >= SUM_W'(WINDOW)) begin
			q = q + 1'b1;
		end
		return q[AVG_W-1:0];
	endfunction

endpackage

>>> hdl/kwa_ram.sv
`timescale 1ns / 1ps

module kwa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 320,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/kwa_front.sv
`timescale 1ns / 1ps

module kwa_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  kwa_pkg::req_t req,
	output logic          push,
	output kwa_pkg::cmd_t cmd,
	input  logic          q_full
);

	import kwa_pkg::*;

	logic [ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0]   key_q [ENTRIES];
	logic [ENTRIES-1:0] hit;
	logic [SLOT_W-1:0]  hit_slot;
	logic [SLOT_W-1:0]  free_slot;
	logic               any_hit;
	logic               any_free;
	logic               set_valid;
	logic               clr_valid;
	logic               accept;

	assign req_ready = !q_full;
	assign accept = req_valid && req_ready;
	assign push = accept;

	// Key match and lowest free slot; the lowest index wins in both.
	always_comb begin
		hit_slot = '0;
		free_slot = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			hit[i] = valid_q[i] && (key_q[i] == req.node_address);
			if (hit[i]) begin
				hit_slot = SLOT_W'(i);
			end
			if (!valid_q[i]) begin
				free_slot = SLOT_W'(i);
			end
		end
		any_hit = |hit;
		any_free = !(&valid_q);
	end

	always_comb begin
		cmd.op = OP_REPORT;
		cmd.slot = hit_slot;
		cmd.status = ST_OK;
		cmd.range_sample = req.range_sample;
		cmd.rssi_sample = req.rssi_sample;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		priority if (req.node_address == '0) begin
			cmd.status = ST_ADDR_ZERO;
		end else begin
			unique case (req.mode)
				MODE_ADD: begin
					if (any_hit) begin
						cmd.status = ST_PRESENT;
					end else if (!any_free) begin
						cmd.status = ST_FULL;
					end else begin
						cmd.op = OP_CLEAR;
						cmd.slot = free_slot;
						set_valid = 1'b1;
					end
				end
				MODE_UPDATE: begin
					if (!any_hit) begin
						cmd.status = ST_NOT_FOUND;
					end else begin
						cmd.op = OP_UPDATE;
					end
				end
				MODE_DELETE: begin
					if (!any_hit) begin
						cmd.status = ST_NOT_FOUND;
					end else begin
						clr_valid = 1'b1;
					end
				end
				MODE_QUERY: begin
					if (!any_hit) begin
						cmd.status = ST_NOT_FOUND;
					end else begin
						cmd.op = OP_QUERY;
					end
				end
				default: begin
					cmd.status = ST_NOT_FOUND;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (accept) begin
			if (set_valid) begin
				valid_q[free_slot] <= 1'b1;
			end
			if (clr_valid) begin
				valid_q[hit_slot] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && set_valid) begin
			key_q[free_slot] <= req.node_address;
		end
	end

endmodule

>>> hdl/kwa_fifo.sv
`timescale 1ns / 1ps

module kwa_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kwa_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output kwa_pkg::cmd_t rdata,
	output logic          avail
);

	import kwa_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full = (cnt_q == QCNT_W'(QDEPTH));
	assign avail = (cnt_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> hdl/kwa_back.sv
`timescale 1ns / 1ps

module kwa_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          avail,
	input  kwa_pkg::cmd_t head,
	output logic          pop,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output kwa_pkg::rsp_t rsp
);

	import kwa_pkg::*;

	// Per-slot window bookkeeping.
	logic [POS_W-1:0]        pos_q  [ENTRIES];
	logic [POS_W-1:0]        fill_q [ENTRIES];
	logic [SUM_W-1:0]        rtot_q [ENTRIES];
	logic signed [SUM_W-1:0] stot_q [ENTRIES];

	// Execute stage.
	logic                    s1_valid_q;
	cmd_t                    cmd_s1;
	logic [ADDR_W-1:0]       addr_s1;
	logic [POS_W-1:0]        pos_s1;
	logic [POS_W-1:0]        fill_s1;
	logic [SUM_W-1:0]        rtot_s1;
	logic signed [SUM_W-1:0] stot_s1;
	logic [PROD_W-1:0]       rprod_s1;
	logic [PROD_W-1:0]       sprod_s1;

	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	logic [ADDR_W-1:0]       rd_addr;
	logic [2*SAMPLE_W-1:0]   rd_data;
	logic [SUM_W-1:0]        sbias_head;
	logic [SUM_W-1:0]        sbias_s1;
	logic                    done;
	logic                    win_full;
	logic [SUM_W-1:0]        r_sub;
	logic [SUM_W-1:0]        s_sub;
	logic [SUM_W-1:0]        rtot_new;
	logic signed [SUM_W-1:0] stot_new;
	logic [POS_W-1:0]        pos_next;
	logic [POS_W-1:0]        fill_next;
	logic [AVG_W-1:0]        s_quot;
	rsp_t                    rsp_d;

	assign pop = avail && !s1_valid_q;
	assign done = s1_valid_q && (!rsp_valid_q || rsp_ready);

	assign rd_addr = ADDR_W'(ADDR_W'(head.slot) * ADDR_W'(WINDOW))
		+ ADDR_W'(pos_q[head.slot]);
	assign sbias_head = $unsigned(stot_q[head.slot]) + RSSI_BIAS;
	assign sbias_s1 = $unsigned(stot_s1) + RSSI_BIAS;

	kwa_ram #(
		.WIDTH(2 * SAMPLE_W),
		.DEPTH(MEM_DEPTH)
	) u_win (
		.clk(clk),
		.rd_en(pop),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(done && (cmd_s1.op == OP_UPDATE)),
		.wr_addr(addr_s1),
		.wr_data({cmd_s1.range_sample, cmd_s1.rssi_sample})
	);

	always_comb begin
		win_full = (fill_s1 == POS_W'(WINDOW));
		r_sub = '0;
		s_sub = '0;
		if (win_full) begin
			r_sub = SUM_W'(rd_data[2*SAMPLE_W-1:SAMPLE_W]);
			s_sub = SUM_W'($signed(rd_data[SAMPLE_W-1:0]));
		end
		rtot_new = rtot_s1 - r_sub + SUM_W'(cmd_s1.range_sample);
		stot_new = $signed($unsigned(stot_s1) - s_sub + SUM_W'(cmd_s1.rssi_sample));
		pos_next = (pos_s1 == POS_W'(WINDOW - 1)) ? '0 : pos_s1 + 1'b1;
		fill_next = win_full ? fill_s1 : fill_s1 + 1'b1;

		// The biased quotient is offset by 2^15; flipping the top bit
		// takes the offset back out in 16-bit two's complement.
		s_quot = win_quot(sprod_s1, sbias_s1);
		rsp_d.status = cmd_s1.status;
		rsp_d.range_mean = '0;
		rsp_d.rssi_mean = '0;
		if (cmd_s1.op == OP_QUERY) begin
			rsp_d.range_mean = win_quot(rprod_s1, rtot_s1);
			rsp_d.rssi_mean = $signed({~s_quot[AVG_W-1], s_quot[AVG_W-2:0]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				pos_q[i] <= '0;
				fill_q[i] <= '0;
				rtot_q[i] <= '0;
				stot_q[i] <= '0;
			end
		end else begin
			if (pop) begin
				s1_valid_q <= 1'b1;
			end else if (done) begin
				s1_valid_q <= 1'b0;
			end
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (done) begin
				unique case (cmd_s1.op)
					OP_CLEAR: begin
						pos_q[cmd_s1.slot] <= '0;
						fill_q[cmd_s1.slot] <= '0;
						rtot_q[cmd_s1.slot] <= '0;
						stot_q[cmd_s1.slot] <= '0;
					end
					OP_UPDATE: begin
						pos_q[cmd_s1.slot] <= pos_next;
						fill_q[cmd_s1.slot] <= fill_next;
						rtot_q[cmd_s1.slot] <= rtot_new;
						stot_q[cmd_s1.slot] <= stot_new;
					end
					OP_REPORT, OP_QUERY: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1 <= head;
			addr_s1 <= rd_addr;
			pos_s1 <= pos_q[head.slot];
			fill_s1 <= fill_q[head.slot];
			rtot_s1 <= rtot_q[head.slot];
			stot_s1 <= stot_q[head.slot];
			rprod_s1 <= PROD_W'(rtot_q[head.slot]) * PROD_W'(RECIP);
			sprod_s1 <= PROD_W'(sbias_head) * PROD_W'(RECIP);
		end
		if (done) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

>>> hdl/keyed_link_window_average_table.sv
`timescale 1ns / 1ps

// Channel  | Signals                     | Payload  | Transfer when
// request  | req_valid, req_ready, req   | req_t    | req_valid && req_ready
// response | rsp_valid, rsp_ready, rsp   | rsp_t    | rsp_valid && rsp_ready
//
// In the execute stage an item first reads the window memory and forms the
// reciprocal products, then finishes the sums, writes the memory and loads
// the response register. Requests are accepted one per cycle until the
// two-entry command queue is full; a response is loaded into its register
// after the command has passed through the queue and the execute stage.
// Reset is asynchronous; there is no clearing pass, since the per-slot fill
// counts say which window places hold samples.
// A stalled response holds the execute stage, which in turn fills the queue
// and drops req_ready.

module keyed_link_window_average_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  kwa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output kwa_pkg::rsp_t rsp
);

	import kwa_pkg::*;

	// Classified commands from the front end, in arrival order.
	cmd_t push_cmd;
	cmd_t head_cmd;
	logic push;
	logic q_full;
	logic q_avail;
	logic pop;

	// The front end owns the key table. Adds and deletes take effect there
	// at the request transfer, so every later request is classified against
	// the table as the preceding items leave it.
	kwa_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.push(push),
		.cmd(push_cmd),
		.q_full(q_full)
	);

	// Short command queue that lets the front end keep taking requests
	// while the back end works on an earlier one or waits on the response.
	kwa_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(push_cmd),
		.full(q_full),
		.pop(pop),
		.rdata(head_cmd),
		.avail(q_avail)
	);

	// The back end owns the sample windows and running sums. It clears a
	// slot's bookkeeping for an add, does the read-modify-write of the ring
	// for an update and divides the sums by the window length for a query.
	kwa_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.avail(q_avail),
		.head(head_cmd),
		.pop(pop),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

endmodule

>>> hdl/kwa_checker.sv
`timescale 1ns / 1ps

module kwa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input kwa_pkg::rsp_t rsp
);

	import kwa_pkg::*;

	localparam int CAP = QDEPTH + 2;
	localparam int CNT_W = $clog2(CAP + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             req_xfer;
	logic             rsp_xfer;

	assign req_xfer = req_valid && req_ready;
	assign rsp_xfer = rsp_valid && rsp_ready;

	// Items accepted and not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req_xfer && !rsp_xfer) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (rsp_xfer && !req_xfer) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_rsp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK)
		|-> (rsp.range_mean == '0) && (rsp.rssi_mean == '0))
		else $error("nonzero average on a failed request");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (cnt_q != '0))
		else $error("response without an outstanding request");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |-> (cnt_q < CNT_W'(CAP)))
		else $error("request accepted beyond internal capacity");

endmodule

bind keyed_link_window_average_table kwa_checker u_kwa_checker (.*);
